// ===== sv/short_long_key_press_detector_macros.svh =====
// assertion macros for the short/long key press detector
`ifndef SHORT_LONG_KEY_PRESS_DETECTOR_MACROS_SVH
`define SHORT_LONG_KEY_PRESS_DETECTOR_MACROS_SVH
`ifndef SYNTHESIS
// property checked outside reset
`define SLKPD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// property checked on every edge, reset included
`define SLKPD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SLKPD_ASSERT(label, clk, rst, prop, msg)
`define SLKPD_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== sv/slkpd_pkg.sv =====
// shared types, constants and helper function of the key press detector
`timescale 1ns / 1ps
package slkpd_pkg;

   // key word geometry
   localparam int KEY_COUNT = 30;
   localparam int CNT_W     = 5;
   localparam int HOLD_W    = 16;

   typedef logic [KEY_COUNT-1:0] key_word_type;
   typedef logic [CNT_W-1:0]     key_cnt_type;
   typedef logic [HOLD_W-1:0]    hold_type;

   localparam key_word_type KEY_WORD_ONES = {KEY_COUNT{1'b1}};

   // hold counter rewind window
   localparam hold_type HOLD_CAP    = 16'd60000;
   localparam hold_type HOLD_REWIND = 16'd2000;

   // configuration registers
   localparam int CSR_IDX_W = 8;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_LONG_HOLD  = 8'd0;
   localparam csr_idx_type CSR_SHORT_HOLD = 8'd1;
   localparam hold_type LONG_HOLD_RESET  = 16'd100;
   localparam hold_type SHORT_HOLD_RESET = 16'd2;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      hold_type long_hold;
      hold_type short_hold;
   } thresh_type;

   typedef struct packed {
      key_word_type short_word;
      key_word_type long_word;
      key_cnt_type  held_count;
   } entry_type;

   // population count through a balanced adder tree
   function automatic key_cnt_type count_keys(input key_word_type w);
      logic [31:0] p;
      logic [1:0]  s1 [16];
      logic [2:0]  s2 [8];
      logic [3:0]  s3 [4];
      logic [4:0]  s4 [2];
      logic [5:0]  s5;
      int          i;
      p = 32'(w);
      for (i = 0; i < 16; i++) s1[i] = {1'b0, p[2*i]} + {1'b0, p[2*i+1]};
      for (i = 0; i < 8; i++)  s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
      for (i = 0; i < 4; i++)  s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
      for (i = 0; i < 2; i++)  s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
      s5 = {1'b0, s4[0]} + {1'b0, s4[1]};
      return s5[CNT_W-1:0];
   endfunction

endpackage

// ===== sv/slkpd_front.sv =====
// front end: takes a key scan item, updates the press state, queues the words
`timescale 1ns / 1ps
module slkpd_front
   import slkpd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  thresh_type   thresh,
   input  logic         item_valid,
   input  key_word_type raw_keys,
   input  logic         q_full,
   output logic         item_ready,
   output logic         q_push,
   output entry_type    q_data
);

   key_word_type now_ff, now_in;
   key_word_type short_ff, short_in;
   key_word_type long_ff, long_in;
   hold_type     hold_ff, hold_in;

   key_word_type pressed;
   key_word_type short_toggled;
   hold_type     hold_inc;
   logic         take;

   assign item_ready = !q_full;
   assign take       = item_valid && item_ready;
   assign q_push     = take;

   // next press state for the item in flight
   always_comb begin
      pressed       = ~raw_keys & KEY_WORD_ONES;
      short_toggled = short_ff ^ (now_ff & ~pressed);
      hold_inc      = hold_ff + 16'd1;
      long_in       = long_ff;
      hold_in       = hold_inc;
      short_in      = short_toggled;
      if ((now_ff ^ long_ff) != '0) begin
         if (hold_ff > thresh.long_hold) begin
            long_in = long_ff | pressed;
            if (hold_inc >= HOLD_CAP) begin
               hold_in = HOLD_REWIND;
            end
         end
         if (hold_in > thresh.short_hold) begin
            short_in = short_toggled & pressed;
         end
      end else begin
         hold_in  = '0;
         long_in  = long_ff & pressed;
         short_in = short_toggled & pressed;
      end
   end

   // queue entry carries the words and the held key count
   always_comb begin
      q_data.short_word = short_in;
      q_data.long_word  = long_in;
      q_data.held_count = count_keys(long_in);
   end

   // state registers advance once per accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff   <= '0;
         short_ff <= '0;
         long_ff  <= '0;
         hold_ff  <= '0;
      end else if (take) begin
         now_ff   <= pressed;
         short_ff <= short_in;
         long_ff  <= long_in;
         hold_ff  <= hold_in;
      end
   end

endmodule

// ===== sv/slkpd_queue.sv =====
// short queue of classified ticks between front and back
`timescale 1ns / 1ps
module slkpd_queue
   import slkpd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   input  logic      pop,
   output logic      full,
   output logic      rd_valid,
   output entry_type rd_data
);

   entry_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  level_ff, level_in;
   logic               do_pop;

   assign full     = (level_ff == QCNT_W'(QUEUE_DEPTH));
   assign rd_valid = (level_ff != '0);
   assign do_pop   = pop && rd_valid;
   assign rd_data  = mem_ff[rd_ptr_ff];

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         level_in = level_ff + 1'b1;
      end else if (do_pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/slkpd_back.sv =====
// back end: walks the long-key word and emits one result item per held key, or a single item when none is held
`timescale 1ns / 1ps
module slkpd_back
   import slkpd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         q_valid,
   input  entry_type    q_data,
   output logic         q_pop,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output key_word_type out_short,
   output key_word_type out_long,
   output logic         out_any,
   output key_cnt_type  out_count,
   output key_cnt_type  out_position,
   output logic         out_last
);

   // working tick
   logic         busy_ff, busy_in;
   key_word_type rem_ff;
   key_word_type short_ff;
   key_word_type long_ff;
   key_cnt_type  count_ff;

   // output register
   logic         valid_ff, valid_in;
   key_word_type o_short_ff;
   key_word_type o_long_ff;
   logic         o_any_ff;
   key_cnt_type  o_count_ff;
   key_cnt_type  o_pos_ff;
   logic         o_last_ff;

   key_word_type lowest;
   key_word_type rem_next;
   key_cnt_type  position;
   logic         is_last;
   logic         advance;

   // lowest remaining key and its 1-based position
   always_comb begin
      lowest   = rem_ff & (~rem_ff + 1'b1);
      rem_next = rem_ff & ~lowest;
      is_last  = (rem_next == '0);
      position = '0;
      for (int i = 0; i < KEY_COUNT; i++) begin
         if (lowest[i]) begin
            position = position | CNT_W'(i + 1);
         end
      end
   end

   // handshake between working tick, queue and output register
   always_comb begin
      advance  = busy_ff && (!valid_ff || rsp_tready);
      q_pop    = q_valid && (!busy_ff || (advance && is_last));
      busy_in  = q_pop ? 1'b1 : (advance && is_last) ? 1'b0 : busy_ff;
      valid_in = advance ? 1'b1 : rsp_tready ? 1'b0 : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   // working tick payload
   always_ff @(posedge clock) begin
      if (q_pop) begin
         rem_ff   <= q_data.long_word;
         short_ff <= q_data.short_word;
         long_ff  <= q_data.long_word;
         count_ff <= q_data.held_count;
      end else if (advance) begin
         rem_ff <= rem_next;
      end
   end

   // result item payload
   always_ff @(posedge clock) begin
      if (advance) begin
         o_short_ff <= short_ff;
         o_long_ff  <= long_ff;
         o_any_ff   <= (count_ff != '0);
         o_count_ff <= count_ff;
         o_pos_ff   <= position;
         o_last_ff  <= is_last;
      end
   end

   assign rsp_tvalid   = valid_ff;
   assign out_short    = o_short_ff;
   assign out_long     = o_long_ff;
   assign out_any      = o_any_ff;
   assign out_count    = o_count_ff;
   assign out_position = o_pos_ff;
   assign out_last     = o_last_ff;

endmodule

// ===== sv/short_long_key_press_detector.sv =====
// top level of the short/long key press detector
//
//  channel   dir   handshake              payload
//  req       in    req_tvalid/req_tready  req_tdata: raw_keys
//  rsp       out   rsp_tvalid/rsp_tready  rsp_tdata, rsp_tlast
//  csr       in    csr_valid/csr_ready    csr_index, csr_data
//
// the front takes one scan item per cycle while the two-entry queue has room
// the back emits one result item per cycle while rsp_tready is high: max(1, held long keys) items a tick
// a scan item passes through the queue, the working tick and the output register before its first result item shows
// reset clears press state, queue and output valid and loads default thresholds
// a stalled rsp channel fills the queue, then req_tready drops
`timescale 1ns / 1ps
`include "short_long_key_press_detector_macros.svh"
module short_long_key_press_detector
   import slkpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // key scan items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [29:0] raw_keys, [31:30] zero
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [29:0] short_keys, [59:30] long_keys, [60] any_held,
                                    // [65:61] held_count, [70:66] held_position, [71] zero
   output logic        rsp_tlast,
   // threshold registers
   input  logic        csr_valid,
   output logic        csr_ready,
   input  csr_idx_type csr_index,
   input  logic [15:0] csr_data
);

   thresh_type   thresh_ff, thresh_in;
   logic         q_full;
   logic         q_push;
   entry_type    q_wdata;
   logic         q_pop;
   logic         q_valid;
   entry_type    q_rdata;
   key_word_type out_short;
   key_word_type out_long;
   logic         out_any;
   key_cnt_type  out_count;
   key_cnt_type  out_position;
   logic         out_last;

   // threshold registers, unknown index is dropped
   assign csr_ready = 1'b1;

   always_comb begin
      thresh_in = thresh_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_LONG_HOLD:  thresh_in.long_hold  = csr_data;
            CSR_SHORT_HOLD: thresh_in.short_hold = csr_data;
            default:        thresh_in = thresh_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff.long_hold  <= LONG_HOLD_RESET;
         thresh_ff.short_hold <= SHORT_HOLD_RESET;
      end else begin
         thresh_ff <= thresh_in;
      end
   end

   slkpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .thresh     (thresh_ff),
      .item_valid (req_tvalid),
      .raw_keys   (req_tdata[KEY_COUNT-1:0]),
      .q_full     (q_full),
      .item_ready (req_tready),
      .q_push     (q_push),
      .q_data     (q_wdata)
   );

   slkpd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .full      (q_full),
      .rd_valid  (q_valid),
      .rd_data   (q_rdata)
   );

   slkpd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_data       (q_rdata),
      .q_pop        (q_pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .out_short    (out_short),
      .out_long     (out_long),
      .out_any      (out_any),
      .out_count    (out_count),
      .out_position (out_position),
      .out_last     (out_last)
   );

   // result packing
   assign rsp_tdata = {1'b0, out_position, out_count, out_any, out_long, out_short};
   assign rsp_tlast = out_last;

   // checks
   `SLKPD_ASSERT_ALWAYS(a_idle_after_reset, clock, reset |=> !rsp_tvalid, "result valid after reset")
   `SLKPD_ASSERT(a_none_is_single, clock, reset, (rsp_tvalid && !out_any) |-> (out_last && out_position == '0), "no-key tick must be a single item")
   `SLKPD_ASSERT(a_any_matches_count, clock, reset, rsp_tvalid |-> (out_any == (out_count != '0)), "held flag disagrees with count")
   `SLKPD_ASSERT(a_position_in_range, clock, reset, (rsp_tvalid && out_any) |-> (out_position != '0 && out_position <= KEY_COUNT), "listed position out of range")

endmodule
